[hw/rtl/i2c_master_write_engine_core_assert.svh]
// Assertion macros for the I2C master write engine.
// Included by the top level; no other dependencies.
`ifndef I2C_MASTER_WRITE_ENGINE_CORE_ASSERT_SVH
`define I2C_MASTER_WRITE_ENGINE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("assertion failed: condition must never hold");
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed: implication violated");
`else
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`endif
`endif

[hw/rtl/i2cmw_pkg.sv]
// Shared types and constants for the I2C master write engine.
// No dependencies.
package i2cmw_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam int unsigned TPM_W  = 10;
	localparam int unsigned ACK_W  = 16;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [TPM_W-1:0] TPM_RESET = 10'd216;
	localparam logic [ACK_W-1:0] ACK_RESET = 16'd250;

	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_US = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT  = 1'd1;

	localparam logic [2:0] US_START = 3'd4;
	localparam logic [2:0] US_BIT   = 3'd2;
	localparam logic [2:0] US_ACK   = 3'd1;
	localparam logic [2:0] US_STOP  = 3'd4;
	localparam logic [2:0] US_NONE  = 3'd0;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [12:0] {
		PH_IDLE     = 13'b0000000000001,
		PH_HOLD     = 13'b0000000000010,
		PH_START_A  = 13'b0000000000100,
		PH_START_B  = 13'b0000000001000,
		PH_BIT_SET  = 13'b0000000010000,
		PH_BIT_HIGH = 13'b0000000100000,
		PH_BIT_LOW  = 13'b0000001000000,
		PH_ACK_PREP = 13'b0000010000000,
		PH_ACK_RISE = 13'b0000100000000,
		PH_ACK_POLL = 13'b0001000000000,
		PH_STOP_A   = 13'b0010000000000,
		PH_STOP_B   = 13'b0100000000000,
		PH_STOP_C   = 13'b1000000000000
	} phase_t;

	typedef struct packed {
		logic       is_byte;
		logic [7:0] data;
		logic       first;
		logic       last;
		logic       sda;
	} item_t;

	typedef struct packed {
		logic scl;
		logic sda;
		logic drv;
		logic need;
		logic done;
		logic nack;
	} res_t;

	typedef struct packed {
		logic                  wr;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

endpackage

[hw/rtl/i2cmw_front.sv]
// Front end: classifies incoming items and queues them for the sequencer.
// Depends on i2cmw_pkg.
module i2cmw_front #(
	parameter int unsigned DEPTH = i2cmw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               cmd,
	input  logic [7:0]         data_byte,
	input  logic               first_of_transfer,
	input  logic               last_of_transfer,
	input  logic               sda_sample,
	output logic               item_valid,
	output i2cmw_pkg::item_t   item,
	input  logic               item_take
);
	import i2cmw_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              wr_en;
	logic              rd_en;
	item_t             item_in;

	assign item_in.is_byte = cmd;
	assign item_in.data    = data_byte;
	assign item_in.first   = first_of_transfer;
	assign item_in.last    = last_of_transfer;
	assign item_in.sda     = sda_sample;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign item_valid = (count_q != '0);
	assign item       = mem_q[rd_ptr_q];
	assign wr_en      = push && !full;
	assign rd_en      = item_take && item_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/i2cmw_back.sv]
// Back end: bus phase sequencer, one queued item per cycle while the result queue has room, plus config registers.
// Depends on i2cmw_pkg.
module i2cmw_back (
	input  logic                clk,
	input  logic                arst_n,
	input  i2cmw_pkg::cfg_wr_t  cfg,
	input  logic                item_valid,
	input  i2cmw_pkg::item_t    item,
	output logic                item_take,
	input  logic                res_full,
	output logic                res_push,
	output i2cmw_pkg::res_t     res
);
	import i2cmw_pkg::*;

	logic [TPM_W-1:0] tpm_q;
	logic [ACK_W-1:0] ack_to_q;

	phase_t           phase_q;
	logic [3:0]       bits_q;
	logic [7:0]       shift_q;
	logic [TPM_W-1:0] div_q;
	logic [2:0]       delay_q;
	logic [ACK_W-1:0] polls_q;
	logic             stop_q;

	phase_t           ph_n;
	logic [3:0]       bits_n;
	logic [7:0]       shift_n;
	logic [TPM_W-1:0] div_n;
	logic [2:0]       delay_n;
	logic [ACK_W-1:0] polls_n;
	logic             stop_n;
	res_t             res_n;

	assign item_take = item_valid && !res_full;
	assign res_push  = item_take;
	assign res       = res_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q    <= TPM_RESET;
			ack_to_q <= ACK_RESET;
		end else if (cfg.wr) begin
			unique case (cfg.idx)
				REG_TICKS_PER_US: tpm_q    <= cfg.data[TPM_W-1:0];
				REG_ACK_TIMEOUT:  ack_to_q <= cfg.data[ACK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		logic err;
		ph_n    = phase_q;
		bits_n  = bits_q;
		shift_n = shift_q;
		div_n   = div_q;
		delay_n = delay_q;
		polls_n = polls_q;
		stop_n  = stop_q;
		err     = 1'b0;
		res_n   = '0;
		priority if (item.is_byte) begin
			if (phase_q == PH_IDLE || phase_q == PH_HOLD) begin
				shift_n = item.data;
				bits_n  = BITS_PER_BYTE;
				stop_n  = item.last;
				div_n   = '0;
				if (item.first || phase_q == PH_IDLE) begin
					ph_n    = PH_START_A;
					delay_n = US_START;
				end else begin
					ph_n    = PH_BIT_SET;
					delay_n = US_BIT;
				end
			end
		end else if (phase_q == PH_ACK_POLL) begin
			if (!item.sda) begin
				div_n = '0;
				if (stop_q) begin
					bits_n  = 4'd0;
					stop_n  = 1'b0;
					ph_n    = PH_STOP_A;
					delay_n = US_STOP;
				end else begin
					ph_n    = PH_HOLD;
					delay_n = US_NONE;
				end
			end else if (polls_q >= ack_to_q) begin
				bits_n  = 4'd1;
				stop_n  = 1'b0;
				div_n   = '0;
				ph_n    = PH_STOP_A;
				delay_n = US_STOP;
			end else begin
				polls_n = polls_q + 1'b1;
			end
		end else if (phase_q != PH_IDLE && phase_q != PH_HOLD) begin
			err   = bits_q[0];
			div_n = div_q + 1'b1;
			if (div_n >= tpm_q) begin
				div_n   = '0;
				delay_n = delay_q - 1'b1;
				if (delay_n == 3'd0) begin
					unique case (phase_q)
						PH_START_A: begin
							ph_n    = PH_START_B;
							delay_n = US_START;
						end
						PH_START_B, PH_BIT_LOW: begin
							ph_n    = PH_BIT_SET;
							delay_n = US_BIT;
							if (phase_q == PH_BIT_LOW) begin
								shift_n = {shift_q[6:0], 1'b0};
								bits_n  = bits_q - 1'b1;
								if (bits_n == 4'd0) begin
									ph_n    = PH_ACK_PREP;
									delay_n = US_ACK;
								end
							end
						end
						PH_BIT_SET: begin
							ph_n    = PH_BIT_HIGH;
							delay_n = US_BIT;
						end
						PH_BIT_HIGH: begin
							ph_n    = PH_BIT_LOW;
							delay_n = US_BIT;
						end
						PH_ACK_PREP: begin
							ph_n    = PH_ACK_RISE;
							delay_n = US_ACK;
						end
						PH_ACK_RISE: begin
							polls_n = '0;
							ph_n    = PH_ACK_POLL;
							delay_n = US_NONE;
						end
						PH_STOP_A: begin
							ph_n    = PH_STOP_B;
							delay_n = US_STOP;
						end
						PH_STOP_B: begin
							ph_n    = PH_STOP_C;
							delay_n = US_STOP;
						end
						PH_STOP_C: begin
							ph_n       = PH_IDLE;
							delay_n    = US_NONE;
							res_n.done = 1'b1;
							res_n.nack = err;
							bits_n     = 4'd0;
						end
						default: begin
							ph_n    = PH_IDLE;
							delay_n = US_NONE;
						end
					endcase
				end
			end
		end else begin
		end

		unique case (ph_n)
			PH_HOLD: begin
				res_n.scl = 1'b0; res_n.sda = 1'b1; res_n.drv = 1'b0;
			end
			PH_START_A: begin
				res_n.scl = 1'b1; res_n.sda = 1'b1; res_n.drv = 1'b1;
			end
			PH_START_B: begin
				res_n.scl = 1'b1; res_n.sda = 1'b0; res_n.drv = 1'b1;
			end
			PH_BIT_SET, PH_BIT_LOW: begin
				res_n.scl = 1'b0; res_n.sda = shift_n[7]; res_n.drv = 1'b1;
			end
			PH_BIT_HIGH: begin
				res_n.scl = 1'b1; res_n.sda = shift_n[7]; res_n.drv = 1'b1;
			end
			PH_ACK_PREP: begin
				res_n.scl = 1'b0; res_n.sda = 1'b1; res_n.drv = 1'b0;
			end
			PH_ACK_RISE, PH_ACK_POLL: begin
				res_n.scl = 1'b1; res_n.sda = 1'b1; res_n.drv = 1'b0;
			end
			PH_STOP_A: begin
				res_n.scl = 1'b0; res_n.sda = 1'b0; res_n.drv = 1'b1;
			end
			PH_STOP_B: begin
				res_n.scl = 1'b1; res_n.sda = 1'b0; res_n.drv = 1'b1;
			end
			default: begin
				res_n.scl = 1'b1; res_n.sda = 1'b1; res_n.drv = 1'b1;
			end
		endcase
		res_n.need = (ph_n == PH_IDLE) || (ph_n == PH_HOLD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bits_q  <= '0;
			shift_q <= '0;
			div_q   <= '0;
			delay_q <= '0;
			polls_q <= '0;
			stop_q  <= 1'b0;
		end else if (item_take) begin
			phase_q <= ph_n;
			bits_q  <= bits_n;
			shift_q <= shift_n;
			div_q   <= div_n;
			delay_q <= delay_n;
			polls_q <= polls_n;
			stop_q  <= stop_n;
		end
	end

endmodule

[hw/rtl/i2cmw_res_q.sv]
// Result queue between the sequencer and the output channel.
// Depends on i2cmw_pkg.
module i2cmw_res_q #(
	parameter int unsigned DEPTH = i2cmw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_push,
	input  i2cmw_pkg::res_t  res,
	output logic             res_full,
	output logic             empty,
	input  logic             pop,
	output i2cmw_pkg::res_t  res_out
);
	import i2cmw_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	res_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_en;
	logic             rd_en;

	assign res_full = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign res_out  = mem_q[rd_ptr_q];
	assign wr_en    = res_push && !res_full;
	assign rd_en    = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/i2c_master_write_engine_core.sv]
// I2C master write engine, top level.
// Depends on i2cmw_pkg, i2cmw_front, i2cmw_back, i2cmw_res_q and the assert header.
//
// Input channel (push/full): each item is either a timer tick (cmd = 0, with
// the sampled SDA level) or a byte to send (cmd = 1, with start/stop marks).
// Every accepted item yields exactly one result on the output channel
// (empty/pop): SCL/SDA levels, SDA drive enable, need_byte, transfer_done
// and nack_error.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
// ticks per microsecond, index 1 the acknowledge timeout. cfg_ready is always
// high; write only while no item is in flight.
// Throughput: one item per clock while the result queue has room, set by the phase sequencer.
// Path: an accepted item is registered in the input queue, then the sequencer
// writes its result into the result queue, from which it can be popped.
// Reset: both queues empty, bus idle with lines high, registers at defaults.
// When pop stays low the result queue fills, the sequencer stops taking
// items, and full rises once the input queue is also full; nothing is lost.
module i2c_master_write_engine_core #(
	parameter int unsigned QUEUE_DEPTH = i2cmw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic                               cmd,
	input  logic [7:0]                         data_byte,
	input  logic                               first_of_transfer,
	input  logic                               last_of_transfer,
	input  logic                               sda_sample,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [i2cmw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [i2cmw_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                               empty,
	input  logic                               pop,
	output logic                               scl_level,
	output logic                               sda_level,
	output logic                               sda_drive,
	output logic                               need_byte,
	output logic                               transfer_done,
	output logic                               nack_error
);
	import i2cmw_pkg::*;

	`include "i2c_master_write_engine_core_assert.svh"

	logic    item_valid;
	item_t   item;
	logic    item_take;
	logic    res_full;
	logic    res_push;
	res_t    res;
	res_t    res_out;
	cfg_wr_t cfg;
	logic    bus_free;

	assign cfg_ready = 1'b1;
	assign cfg.wr    = cfg_valid && cfg_ready;
	assign cfg.idx   = cfg_index;
	assign cfg.data  = cfg_data;

	i2cmw_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.cmd               (cmd),
		.data_byte         (data_byte),
		.first_of_transfer (first_of_transfer),
		.last_of_transfer  (last_of_transfer),
		.sda_sample        (sda_sample),
		.item_valid        (item_valid),
		.item              (item),
		.item_take         (item_take)
	);

	i2cmw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res)
	);

	i2cmw_res_q #(
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.res_out  (res_out)
	);

	assign scl_level     = res_out.scl;
	assign sda_level     = res_out.sda;
	assign sda_drive     = res_out.drv;
	assign need_byte     = res_out.need;
	assign transfer_done = res_out.done;
	assign nack_error    = res_out.nack;

	assign bus_free = scl_level && sda_level && sda_drive && need_byte;

	`ASSERT_IMPLIES(a_take_has_item, clk, arst_n, item_take, item_valid)
	`ASSERT_NEVER(a_push_into_full, clk, arst_n, res_push && res_full)
	`ASSERT_NEVER(a_nack_without_done, clk, arst_n, !empty && nack_error && !transfer_done)
	`ASSERT_IMPLIES(a_done_bus_idle, clk, arst_n, !empty && transfer_done, bus_free)

endmodule

[tb/sv/i2c_master_write_engine_core_tb.sv]
// Self-checking testbench for the I2C master write engine: a scoreboard class
// predicts the bus levels for every transfer and checks each popped result.
// Depends on i2cmw_pkg and the i2c_master_write_engine_core top level.
`timescale 1ns / 1ps

module i2c_master_write_engine_core_tb;
	import i2cmw_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned N_SETTINGS = 7;

	class i2c_write_scoreboard;
		phase_t      phase;
		logic [3:0]  bits_left;
		logic [7:0]  shift_byte;
		logic [9:0]  tick_div;
		logic [2:0]  delay_left;
		logic [15:0] ack_polls;
		logic        stop_pending;
		logic [9:0]  ticks_per_us;
		logic [15:0] ack_limit;
		res_t        bus_levels_q[$];
		int unsigned errors;
		int unsigned checked;
		int unsigned stops_seen;
		int unsigned nacks_seen;

		function new();
			phase = PH_IDLE;
			bits_left = '0;
			shift_byte = '0;
			tick_div = '0;
			delay_left = '0;
			ack_polls = '0;
			stop_pending = 1'b0;
			ticks_per_us = TPM_RESET;
			ack_limit = ACK_RESET;
			errors = 0;
			checked = 0;
			stops_seen = 0;
			nacks_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_TICKS_PER_US)
				ticks_per_us = value[TPM_W-1:0];
			else if (idx == REG_ACK_TIMEOUT)
				ack_limit = value[ACK_W-1:0];
		endfunction

		function void enter_phase(phase_t next, logic [2:0] us);
			phase = next;
			delay_left = us;
			tick_div = '0;
		endfunction

		function void start_stop(logic err);
			bits_left = {3'b000, err};
			stop_pending = 1'b0;
			enter_phase(PH_STOP_A, US_STOP);
		endfunction

		// advance to the next phase; returns 1 when the stop has completed
		function bit end_phase();
			case (phase)
				PH_START_A: enter_phase(PH_START_B, US_START);
				PH_START_B: enter_phase(PH_BIT_SET, US_BIT);
				PH_BIT_SET: enter_phase(PH_BIT_HIGH, US_BIT);
				PH_BIT_HIGH: enter_phase(PH_BIT_LOW, US_BIT);
				PH_BIT_LOW: begin
					shift_byte = shift_byte << 1;
					bits_left = bits_left - 4'd1;
					if (bits_left == 4'd0)
						enter_phase(PH_ACK_PREP, US_ACK);
					else
						enter_phase(PH_BIT_SET, US_BIT);
				end
				PH_ACK_PREP: enter_phase(PH_ACK_RISE, US_ACK);
				PH_ACK_RISE: begin
					ack_polls = '0;
					enter_phase(PH_ACK_POLL, US_NONE);
				end
				PH_STOP_A: enter_phase(PH_STOP_B, US_STOP);
				PH_STOP_B: enter_phase(PH_STOP_C, US_STOP);
				PH_STOP_C: begin
					enter_phase(PH_IDLE, US_NONE);
					return 1'b1;
				end
				default: enter_phase(PH_IDLE, US_NONE);
			endcase
			return 1'b0;
		endfunction

		function bit bus_idle();
			return phase == PH_IDLE;
		endfunction

		function bit between_bytes();
			return phase == PH_IDLE || phase == PH_HOLD;
		endfunction

		function bit polling_ack();
			return phase == PH_ACK_POLL;
		endfunction

		function int unsigned pending();
			return bus_levels_q.size();
		endfunction

		function void predict_item(item_t it);
			res_t lv;
			logic err;
			lv = '0;
			if (it.is_byte) begin
				if (between_bytes()) begin
					shift_byte = it.data;
					bits_left = BITS_PER_BYTE;
					stop_pending = it.last;
					if (it.first || phase == PH_IDLE)
						enter_phase(PH_START_A, US_START);
					else
						enter_phase(PH_BIT_SET, US_BIT);
				end
			end else if (phase == PH_ACK_POLL) begin
				if (!it.sda) begin
					if (stop_pending)
						start_stop(1'b0);
					else
						enter_phase(PH_HOLD, US_NONE);
				end else if (ack_polls >= ack_limit) begin
					start_stop(1'b1);
				end else begin
					ack_polls = ack_polls + 16'd1;
				end
			end else if (!between_bytes()) begin
				err = bits_left[0];
				tick_div = tick_div + 10'd1;
				if (tick_div >= ticks_per_us) begin
					tick_div = '0;
					delay_left = delay_left - 3'd1;
					if (delay_left == 3'd0 && end_phase()) begin
						lv.done = 1'b1;
						lv.nack = err;
						bits_left = '0;
					end
				end
			end
			case (phase)
				PH_HOLD:     {lv.scl, lv.sda, lv.drv} = 3'b010;
				PH_START_A:  {lv.scl, lv.sda, lv.drv} = 3'b111;
				PH_START_B:  {lv.scl, lv.sda, lv.drv} = 3'b101;
				PH_BIT_SET:  {lv.scl, lv.sda, lv.drv} = {1'b0, shift_byte[7], 1'b1};
				PH_BIT_HIGH: {lv.scl, lv.sda, lv.drv} = {1'b1, shift_byte[7], 1'b1};
				PH_BIT_LOW:  {lv.scl, lv.sda, lv.drv} = {1'b0, shift_byte[7], 1'b1};
				PH_ACK_PREP: {lv.scl, lv.sda, lv.drv} = 3'b010;
				PH_ACK_RISE: {lv.scl, lv.sda, lv.drv} = 3'b110;
				PH_ACK_POLL: {lv.scl, lv.sda, lv.drv} = 3'b110;
				PH_STOP_A:   {lv.scl, lv.sda, lv.drv} = 3'b001;
				PH_STOP_B:   {lv.scl, lv.sda, lv.drv} = 3'b101;
				PH_STOP_C:   {lv.scl, lv.sda, lv.drv} = 3'b111;
				default:     {lv.scl, lv.sda, lv.drv} = 3'b111;
			endcase
			lv.need = between_bytes();
			if (lv.done)
				stops_seen++;
			if (lv.nack)
				nacks_seen++;
			bus_levels_q.push_back(lv);
		endfunction

		function void compare_bit(string field, logic want, logic got);
			if (got !== want) begin
				errors++;
				if (errors <= 40)
					$display("%0t: %s mismatch, expected %0b actual %0b",
						$time, field, want, got);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (bus_levels_q.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t: result with nothing expected, actual %b", $time, got);
				return;
			end
			want = bus_levels_q.pop_front();
			checked++;
			compare_bit("scl_level", want.scl, got.scl);
			compare_bit("sda_level", want.sda, got.sda);
			compare_bit("sda_drive", want.drv, got.drv);
			compare_bit("need_byte", want.need, got.need);
			compare_bit("transfer_done", want.done, got.done);
			compare_bit("nack_error", want.nack, got.nack);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	logic                  cmd;
	logic [7:0]            data_byte;
	logic                  first_of_transfer;
	logic                  last_of_transfer;
	logic                  sda_sample;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  empty;
	logic                  pop;
	logic                  scl_level;
	logic                  sda_level;
	logic                  sda_drive;
	logic                  need_byte;
	logic                  transfer_done;
	logic                  nack_error;

	i2c_write_scoreboard sb;
	int unsigned send_gap_pct;
	int unsigned pop_stall_pct;
	int unsigned total_items;
	int unsigned cycles;
	int unsigned bytes_left;

	int unsigned set_tpm [N_SETTINGS]   = '{1, 2, 1, 16'h0400, 3, 1023, 1};
	int unsigned set_ack [N_SETTINGS]   = '{0, 3, 1, 2, 65535, 5, 250};
	int unsigned set_items [N_SETTINGS] = '{400, 250, 250, 250, 200, 150, 400};
	int unsigned set_gap [N_SETTINGS]   = '{0, 83, 0, 11, 0, 0, 11};
	int unsigned set_stall [N_SETTINGS] = '{0, 0, 83, 11, 0, 0, 11};
	int unsigned set_nack [N_SETTINGS]  = '{40, 40, 50, 45, 30, 40, 20};

	i2c_master_write_engine_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.cmd               (cmd),
		.data_byte         (data_byte),
		.first_of_transfer (first_of_transfer),
		.last_of_transfer  (last_of_transfer),
		.sda_sample        (sda_sample),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.empty             (empty),
		.pop               (pop),
		.scl_level         (scl_level),
		.sda_level         (sda_level),
		.sda_drive         (sda_drive),
		.need_byte         (need_byte),
		.transfer_done     (transfer_done),
		.nack_error        (nack_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			pop <= arst_n && ($urandom_range(0, 99) >= pop_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_result(res_t'{scl_level, sda_level, sda_drive, need_byte,
				transfer_done, nack_error});
	end

	task automatic send_item(input item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		cmd <= it.is_byte;
		data_byte <= it.data;
		first_of_transfer <= it.first;
		last_of_transfer <= it.last;
		sda_sample <= it.sda;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.predict_item(it);
		total_items++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, value[CFG_DATA_W-1:0]);
	endtask

	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// mostly well-formed transfers; a few stray ticks and bytes sent while busy
	task automatic run_phase(input int unsigned n, input int unsigned nack_pct);
		item_t       it;
		bit          quiet;
		int unsigned counted;
		counted = 0;
		while (counted < n) begin
			it.is_byte = 1'b0;
			it.first = 1'($urandom_range(0, 1));
			it.last = 1'($urandom_range(0, 1));
			it.sda = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0: it.data = 8'h00;
				1: it.data = 8'hFF;
				default: it.data = 8'($urandom_range(0, 255));
			endcase
			quiet = sb.between_bytes();
			if (quiet) begin
				if ($urandom_range(0, 99) >= 5) begin
					it.is_byte = 1'b1;
					if (sb.bus_idle() || bytes_left == 0) begin
						bytes_left = $urandom_range(1, 4);
						it.first = ($urandom_range(0, 9) != 0);
					end else begin
						it.first = ($urandom_range(0, 11) == 0);
					end
					it.last = (bytes_left == 1);
					bytes_left--;
				end
			end else begin
				if ($urandom_range(0, 99) < 4)
					it.is_byte = 1'b1;
				else if (sb.polling_ack())
					it.sda = ($urandom_range(0, 99) < nack_pct);
			end
			if (quiet == it.is_byte)
				counted++;
			send_item(it);
		end
	endtask

	initial begin
		sb = new();
		send_gap_pct = 0;
		pop_stall_pct = 0;
		total_items = 0;
		bytes_left = 0;
		arst_n = 1'b0;
		push = 1'b0;
		cmd = 1'b0;
		data_byte = '0;
		first_of_transfer = 1'b0;
		last_of_transfer = 1'b0;
		sda_sample = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// idle ticks, start without the first mark, byte while busy, reset timing
		send_item(item_t'{1'b0, 8'hFF, 1'b1, 1'b1, 1'b0});
		send_item(item_t'{1'b0, 8'h00, 1'b0, 1'b0, 1'b1});
		send_item(item_t'{1'b1, 8'h00, 1'b0, 1'b0, 1'b0});
		send_item(item_t'{1'b1, 8'hFF, 1'b1, 1'b1, 1'b1});
		send_item(item_t'{1'b0, 8'hA5, 1'b1, 1'b0, 1'b1});
		send_item(item_t'{1'b0, 8'h5A, 1'b0, 1'b1, 1'b0});
		send_item(item_t'{1'b0, 8'hFF, 1'b1, 1'b1, 1'b1});
		send_item(item_t'{1'b0, 8'h00, 1'b0, 1'b0, 1'b0});
		bytes_left = 1;

		for (int p = 0; p < N_SETTINGS; p++) begin
			drain();
			write_reg(REG_TICKS_PER_US, set_tpm[p]);
			write_reg(REG_ACK_TIMEOUT, set_ack[p]);
			@(negedge clk);
			cfg_valid <= 1'b0;
			send_gap_pct = set_gap[p];
			pop_stall_pct = set_stall[p];
			run_phase(set_items[p], set_nack[p]);
		end
		drain();

		sb.errors += sb.pending();
		$display("sent %0d items over %0d register settings, checked %0d results",
			total_items, N_SETTINGS, sb.checked);
		$display("saw %0d completed stops, %0d of them after an acknowledge timeout",
			sb.stops_seen, sb.nacks_seen);
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d errors", sb.errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
